>>> rtl/xyse_pkg.sv
// shared constants, codes and control/status types for the step-edge executor
package xyse_pkg;

  // operations
  localparam logic [2:0] OP_ARM    = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;
  localparam logic [2:0] OP_LIMIT  = 3'd5;
  localparam logic [2:0] OP_FAULT  = 3'd6;
  localparam logic [2:0] OP_TICK   = 3'd7;

  // run modes
  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_ARMED     = 3'd1;
  localparam logic [2:0] M_RUNNING   = 3'd2;
  localparam logic [2:0] M_PAUSED    = 3'd3;
  localparam logic [2:0] M_COMPLETED = 3'd4;
  localparam logic [2:0] M_CANCELED  = 3'd5;
  localparam logic [2:0] M_LIMIT     = 3'd6;
  localparam logic [2:0] M_FAULTED   = 3'd7;

  // pending controls
  localparam logic [2:0] P_NONE   = 3'd0;
  localparam logic [2:0] P_PAUSE  = 3'd1;
  localparam logic [2:0] P_CANCEL = 3'd2;
  localparam logic [2:0] P_XLIM   = 3'd3;
  localparam logic [2:0] P_YLIM   = 3'd4;
  localparam logic [2:0] P_FAULT  = 3'd5;

  // end reasons
  localparam logic [2:0] R_NONE     = 3'd0;
  localparam logic [2:0] R_COMPLETE = 3'd1;
  localparam logic [2:0] R_CANCEL   = 3'd2;
  localparam logic [2:0] R_XLIM     = 3'd3;
  localparam logic [2:0] R_YLIM     = 3'd4;
  localparam logic [2:0] R_FAULT    = 3'd5;

  // planner status
  localparam logic [1:0] PS_READY    = 2'd0;
  localparam logic [1:0] PS_COMPLETE = 2'd1;

  // result status codes
  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_EDGE      = 4'd1;
  localparam logic [3:0] ST_COMPLETED = 4'd2;
  localparam logic [3:0] ST_CANCELED  = 4'd3;
  localparam logic [3:0] ST_LIMIT     = 4'd4;
  localparam logic [3:0] ST_FAULTED   = 4'd5;
  localparam logic [3:0] ST_CLEANUP   = 4'd6;
  localparam logic [3:0] ST_ALREADY   = 4'd7;
  localparam logic [3:0] ST_INVALID   = 4'd8;
  localparam logic [3:0] ST_STOPNOW   = 4'd9;
  localparam logic [3:0] ST_DEFERRED  = 4'd10;
  localparam logic [3:0] ST_BUSY      = 4'd11;
  localparam logic [3:0] ST_IMMEDIATE = 4'd12;
  localparam logic [3:0] ST_BADPLAN   = 4'd13;
  localparam logic [3:0] ST_READY     = 4'd14;

  // configuration register indexes
  localparam logic [1:0] CFG_X_TOTAL = 2'd0;
  localparam logic [1:0] CFG_Y_TOTAL = 2'd1;
  localparam logic [1:0] CFG_M_TOTAL = 2'd2;

  localparam int unsigned DW = 32;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_y;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_x;
    logic need_y;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/xyse_div.sv
// iterative unsigned divider, one quotient bit per cycle
module xyse_div
  import xyse_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [DW:0]   sh;
  logic          ge;

  // shift-subtract step
  always_comb begin
    sh     = {rem_q, quo_q[DW-1]};
    ge     = (sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(sh - {1'b0, dvs_q}) : sh[DW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/xyse_ctrl.sv
// sequencing state machine: request capture, spacing divisions, execute
module xyse_ctrl
  import xyse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XGO   = 3'd1;
  localparam logic [2:0] S_XWAIT = 3'd2;
  localparam logic [2:0] S_YGO   = 3'd3;
  localparam logic [2:0] S_YWAIT = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_XGO;
        end
      end
      S_XGO: begin
        if (sts_i.need_x) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_XWAIT;
        end else begin
          state_d = S_YGO;
        end
      end
      S_XWAIT: begin
        if (sts_i.div_done) state_d = S_YGO;
      end
      S_YGO: begin
        cmd_o.div_sel_y = 1'b1;
        if (sts_i.need_y) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_YWAIT;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_YWAIT: begin
        cmd_o.div_sel_y = 1'b1;
        if (sts_i.div_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> rtl/xyse_dp.sv
// datapath: run state, held event, spacing check and result register
module xyse_dp
  import xyse_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctrl_cmd_t     cmd_i,
  output dp_sts_t       sts_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [DW-1:0] cfg_data_i,
  input  logic [2:0]    operation_i,
  input  logic          limit_axis_i,
  input  logic          init_x_high_i,
  input  logic          init_y_high_i,
  input  logic [1:0]    planner_status_i,
  input  logic [1:0]    event_mask_i,
  input  logic [DW-1:0] event_reload_i,
  input  logic [DW-1:0] event_master_index_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    status_code_o,
  output logic [1:0]    edge_mask_o,
  output logic [1:0]    rise_mask_o,
  output logic [1:0]    cleanup_mask_o,
  output logic [1:0]    spacing_flags_o,
  output logic [DW-1:0] reload_now_o,
  output logic [DW-1:0] reload_next_o,
  output logic          update_reload_o,
  output logic          stop_timer_o,
  output logic          signal_done_o,
  output logic [2:0]    run_state_o,
  output logic [2:0]    end_reason_o
);

  // configuration
  logic [DW-1:0] x_tot_q, y_tot_q, m_tot_q;
  // captured request
  logic [2:0]    op_q;
  logic          lax_q, ix_q, iy_q;
  logic [1:0]    pst_q, emask_q;
  logic [DW-1:0] ereload_q, eidx_q;
  // run state
  logic [2:0]    mode_q, mode_d, pend_q, pend_d, rsn_q, rsn_d;
  logic          xl_q, xl_d, yl_q, yl_d, xs_q, xs_d, ys_q, ys_d;
  logic [1:0]    hm_q, hm_d;
  logic [DW-1:0] hr_q, hr_d, hi_q, hi_d, xli_q, xli_d, yli_q, yli_d;
  logic          fx_q, fy_q;
  // result register
  logic          ov_q;
  logic [3:0]    st_q, st_d;
  logic [1:0]    em_q, em_d, rm_q, rm_d, cm_q, cm_d, sf_q, sf_d;
  logic [DW-1:0] rn_q, rn_d, rx_q, rx_d;
  logic          ur_q, ur_d, stp_q, stp_d, dn_q, dn_d;

  // divider
  logic          dv_done;
  logic [DW-1:0] dv_quo, dv_rem, gap;
  logic [DW:0]   hi_bound;
  logic          bad;

  function automatic logic [1:0] prio(input logic [2:0] p);
    case (p)
      P_FAULT:        prio = 2'd3;
      P_XLIM, P_YLIM: prio = 2'd2;
      P_CANCEL:       prio = 2'd1;
      default:        prio = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] term_mode(input logic [2:0] p);
    case (p)
      P_CANCEL:       term_mode = M_CANCELED;
      P_XLIM, P_YLIM: term_mode = M_LIMIT;
      default:        term_mode = M_FAULTED;
    endcase
  endfunction

  function automatic logic [2:0] term_reason(input logic [2:0] p);
    case (p)
      P_CANCEL: term_reason = R_CANCEL;
      P_XLIM:   term_reason = R_XLIM;
      P_YLIM:   term_reason = R_YLIM;
      default:  term_reason = R_FAULT;
    endcase
  endfunction

  function automatic logic [3:0] term_status(input logic [2:0] p);
    case (p)
      P_CANCEL:       term_status = ST_CANCELED;
      P_XLIM, P_YLIM: term_status = ST_LIMIT;
      default:        term_status = ST_FAULTED;
    endcase
  endfunction

  xyse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (m_tot_q),
    .divisor_i  (cmd_i.div_sel_y ? y_tot_q : x_tot_q),
    .done_o     (dv_done),
    .quo_o      (dv_quo),
    .rem_o      (dv_rem)
  );

  // gap since the axis's last edge, checked against floor and ceil of master/axis
  assign gap      = hi_q - (cmd_i.div_sel_y ? yli_q : xli_q);
  assign hi_bound = {1'b0, dv_quo} + {{DW{1'b0}}, (dv_rem != '0)};
  assign bad      = (gap < dv_quo) || ({1'b0, gap} > hi_bound);

  // status towards the controller
  always_comb begin
    sts_o.need_x   = (op_q == OP_TICK) && (mode_q == M_RUNNING) && (pend_q == P_NONE)
                     && hm_q[0] && (x_tot_q != '0) && xs_q;
    sts_o.need_y   = (op_q == OP_TICK) && (mode_q == M_RUNNING) && (pend_q == P_NONE)
                     && hm_q[1] && (y_tot_q != '0) && ys_q;
    sts_o.div_done = dv_done;
    sts_o.out_free = !ov_q || !out_stall_i;
  end

  // request execution
  always_comb begin
    logic [2:0] req;
    logic       act, blk;
    logic [1:0] lv;
    mode_d = mode_q; pend_d = pend_q; rsn_d = rsn_q;
    xl_d = xl_q; yl_d = yl_q; hm_d = hm_q; hr_d = hr_q; hi_d = hi_q;
    xs_d = xs_q; ys_d = ys_q; xli_d = xli_q; yli_d = yli_q;
    st_d = ST_NONE; em_d = '0; rm_d = '0; cm_d = '0; sf_d = '0;
    rn_d = '0; rx_d = '0; ur_d = 1'b0; stp_d = 1'b0; dn_d = 1'b0;
    act = (mode_q == M_ARMED) || (mode_q == M_RUNNING) || (mode_q == M_PAUSED);
    req = P_PAUSE;
    blk = 1'b0;
    lv  = '0;
    case (op_q)
      OP_ARM: begin
        if (act) begin
          st_d = ST_BUSY;
        end else begin
          mode_d = M_IDLE; pend_d = P_NONE; rsn_d = R_NONE;
          hm_d = '0; hr_d = '0; hi_d = '0;
          xs_d = 1'b0; ys_d = 1'b0; xli_d = '0; yli_d = '0;
          xl_d = ix_q; yl_d = iy_q;
          if (pst_q == PS_COMPLETE) begin
            mode_d = M_COMPLETED; rsn_d = R_COMPLETE; st_d = ST_IMMEDIATE;
          end else if (pst_q != PS_READY) begin
            xl_d = 1'b0; yl_d = 1'b0; st_d = ST_BADPLAN;
          end else begin
            hm_d = emask_q; hr_d = ereload_q; hi_d = eidx_q;
            mode_d = M_ARMED; st_d = ST_READY;
          end
        end
      end
      OP_START, OP_RESUME: begin
        if (mode_q == M_RUNNING) begin
          st_d = ST_ALREADY;
        end else if (mode_q != ((op_q == OP_START) ? M_ARMED : M_PAUSED)) begin
          st_d = ST_INVALID;
        end else begin
          mode_d = M_RUNNING; st_d = ST_DEFERRED;
        end
      end
      OP_PAUSE, OP_CANCEL, OP_LIMIT: begin
        if (op_q == OP_CANCEL) req = P_CANCEL;
        else if (op_q == OP_LIMIT) req = lax_q ? P_YLIM : P_XLIM;
        blk = (pend_q != P_NONE) && ((prio(pend_q) > prio(req)) ||
              ((prio(pend_q) == prio(req)) && (pend_q != P_PAUSE)));
        if (mode_q >= M_COMPLETED) begin
          st_d = ST_ALREADY;
        end else if (!act) begin
          st_d = ST_INVALID;
        end else if (blk) begin
          st_d = ST_ALREADY;
        end else if (req == P_PAUSE) begin
          if (mode_q == M_PAUSED) begin
            st_d = ST_ALREADY;
          end else begin
            pend_d = P_NONE; mode_d = M_PAUSED; st_d = ST_STOPNOW;
          end
        end else if (xl_q || yl_q) begin
          pend_d = req;
          if (mode_q == M_PAUSED || mode_q == M_ARMED) mode_d = M_RUNNING;
          st_d = ST_DEFERRED;
        end else begin
          pend_d = P_NONE; mode_d = term_mode(req); rsn_d = term_reason(req);
          st_d = ST_STOPNOW;
        end
      end
      OP_FAULT: begin
        if (act) begin
          if (xl_q || yl_q) begin
            pend_d = P_FAULT; mode_d = M_RUNNING; st_d = ST_CLEANUP;
          end else begin
            pend_d = P_NONE; mode_d = M_FAULTED; rsn_d = R_FAULT;
            st_d = ST_FAULTED; stp_d = 1'b1; dn_d = 1'b1;
          end
        end
      end
      default: begin
        // timer tick
        if (mode_q == M_RUNNING) begin
          if (pend_q != P_NONE) begin
            lv = {yl_q, xl_q};
            if (lv != '0) begin
              rn_d = hr_q; cm_d = lv; em_d = lv;
            end
            xl_d = 1'b0; yl_d = 1'b0;
            pend_d = P_NONE; mode_d = term_mode(pend_q); rsn_d = term_reason(pend_q);
            st_d = term_status(pend_q); stp_d = 1'b1; dn_d = 1'b1;
          end else begin
            st_d = ST_EDGE; rn_d = hr_q; em_d = hm_q;
            xl_d = xl_q ^ hm_q[0];
            yl_d = yl_q ^ hm_q[1];
            rm_d = {hm_q[1] & yl_d, hm_q[0] & xl_d};
            if (hm_q[0] && (x_tot_q != '0)) begin
              sf_d[0] = xs_q & fx_q; xli_d = hi_q; xs_d = 1'b1;
            end
            if (hm_q[1] && (y_tot_q != '0)) begin
              sf_d[1] = ys_q & fy_q; yli_d = hi_q; ys_d = 1'b1;
            end
            if (pst_q[1]) begin
              if (xl_d || yl_d) begin
                pend_d = P_FAULT; st_d = ST_CLEANUP;
              end else begin
                pend_d = P_NONE; mode_d = M_FAULTED; rsn_d = R_FAULT;
                st_d = ST_FAULTED; stp_d = 1'b1; dn_d = 1'b1;
              end
            end else if (pst_q == PS_COMPLETE) begin
              pend_d = P_NONE; mode_d = M_COMPLETED; rsn_d = R_COMPLETE;
              st_d = ST_COMPLETED; stp_d = 1'b1; dn_d = 1'b1;
            end else begin
              hm_d = emask_q; hr_d = ereload_q; hi_d = eidx_q;
              rx_d = ereload_q; ur_d = 1'b1;
            end
          end
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_tot_q <= '0; y_tot_q <= '0; m_tot_q <= '0;
      mode_q <= M_IDLE; pend_q <= P_NONE; rsn_q <= R_NONE;
      xl_q <= 1'b0; yl_q <= 1'b0; xs_q <= 1'b0; ys_q <= 1'b0;
      hm_q <= '0; hr_q <= '0; hi_q <= '0; xli_q <= '0; yli_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_X_TOTAL: x_tot_q <= cfg_data_i;
          CFG_Y_TOTAL: y_tot_q <= cfg_data_i;
          CFG_M_TOTAL: m_tot_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        mode_q <= mode_d; pend_q <= pend_d; rsn_q <= rsn_d;
        xl_q <= xl_d; yl_q <= yl_d; xs_q <= xs_d; ys_q <= ys_d;
        hm_q <= hm_d; hr_q <= hr_d; hi_q <= hi_d; xli_q <= xli_d; yli_q <= yli_d;
      end
      if (cmd_i.exec) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // request capture, spacing flags and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i; lax_q <= limit_axis_i;
      ix_q <= init_x_high_i; iy_q <= init_y_high_i;
      pst_q <= planner_status_i; emask_q <= event_mask_i;
      ereload_q <= event_reload_i; eidx_q <= event_master_index_i;
      fx_q <= 1'b0; fy_q <= 1'b0;
    end else if (dv_done) begin
      if (cmd_i.div_sel_y) fy_q <= bad;
      else fx_q <= bad;
    end
    if (cmd_i.exec) begin
      st_q <= st_d; em_q <= em_d; rm_q <= rm_d; cm_q <= cm_d; sf_q <= sf_d;
      rn_q <= rn_d; rx_q <= rx_d; ur_q <= ur_d; stp_q <= stp_d; dn_q <= dn_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_code_o   = st_q;
  assign edge_mask_o     = em_q;
  assign rise_mask_o     = rm_q;
  assign cleanup_mask_o  = cm_q;
  assign spacing_flags_o = sf_q;
  assign reload_now_o    = rn_q;
  assign reload_next_o   = rx_q;
  assign update_reload_o = ur_q;
  assign stop_timer_o    = stp_q;
  assign signal_done_o   = dn_q;
  assign run_state_o     = mode_q;
  assign end_reason_o    = rsn_q;

endmodule

>>> rtl/xy_step_edge_executor.sv
// top level of the two-axis step-edge executor
// flow: a request goes through states XGO, YGO and EXEC, then its result is
// registered; a tick that checks spacing adds a division per checked axis on the
// shared bit-serial divider. One request at a time: the input stalls until the
// result is registered, and EXEC waits while the last result is stalled
// reset: asynchronous active low, run state idle, step levels low, state regs zero
module xy_step_edge_executor
  import xyse_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [DW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    operation_i,
  input  logic          limit_axis_i,
  input  logic          init_x_high_i,
  input  logic          init_y_high_i,
  input  logic [1:0]    planner_status_i,
  input  logic [1:0]    event_mask_i,
  input  logic [DW-1:0] event_reload_i,
  input  logic [DW-1:0] event_master_index_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    status_code_o,
  output logic [1:0]    edge_mask_o,
  output logic [1:0]    rise_mask_o,
  output logic [1:0]    cleanup_mask_o,
  output logic [1:0]    spacing_flags_o,
  output logic [DW-1:0] reload_now_o,
  output logic [DW-1:0] reload_next_o,
  output logic          update_reload_o,
  output logic          stop_timer_o,
  output logic          signal_done_o,
  output logic [2:0]    run_state_o,
  output logic [2:0]    end_reason_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  xyse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xyse_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (operation_i),
    .limit_axis_i         (limit_axis_i),
    .init_x_high_i        (init_x_high_i),
    .init_y_high_i        (init_y_high_i),
    .planner_status_i     (planner_status_i),
    .event_mask_i         (event_mask_i),
    .event_reload_i       (event_reload_i),
    .event_master_index_i (event_master_index_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_code_o        (status_code_o),
    .edge_mask_o          (edge_mask_o),
    .rise_mask_o          (rise_mask_o),
    .cleanup_mask_o       (cleanup_mask_o),
    .spacing_flags_o      (spacing_flags_o),
    .reload_now_o         (reload_now_o),
    .reload_next_o        (reload_next_o),
    .update_reload_o      (update_reload_o),
    .stop_timer_o         (stop_timer_o),
    .signal_done_o        (signal_done_o),
    .run_state_o          (run_state_o),
    .end_reason_o         (end_reason_o)
  );

endmodule
